FILE: hw/rtl/fbfla_pkg.sv
package fbfla_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 1024;

   // fixed field widths of the request and response transactions
   localparam int REQ_W    = 2;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int STATUS_W = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC_ONE  = 2'd0,
      REQ_ALLOC_LIST = 2'd1,
      REQ_FREE_ONE   = 2'd2,
      REQ_FREE_LIST  = 2'd3
   } req_code_type;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CAP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_ALLOC = 7'b0001000,
      ST_WALK  = 7'b0010000,
      ST_CHAIN = 7'b0100000,
      ST_FREE  = 7'b1000000
   } state_type;

endpackage

FILE: hw/rtl/fixed_block_free_list_allocator_core.sv
// free one, null or out-of-range requests, and requests that fail at once
//   strobe a response the cycle after start; allocate one first passes through READ and ALLOC.
// allocate list of n blocks: READ, WALK per block to walk the free list, then READ, CHAIN per pop.
// free list of k blocks: each step is a read then a write of the link RAM.
// after reset busy stays high while the link RAM is initialized.
// responses are strobed for one cycle; the receiver cannot stall them.
module fixed_block_free_list_allocator_core import fbfla_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [IDX_W-1:0]    req_block_index,
   input  logic                req_block_present,
   input  logic [CNT_W-1:0]    req_block_count,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_result_index,
   output logic                rsp_result_present,
   output logic [CNT_W-1:0]    rsp_free_blocks
);

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int LW = IW + 1;

   state_type state_ff, state_in;
   state_type after_ff, after_in;

   logic          head_ok_ff, head_ok_in;
   logic [IW-1:0] head_idx_ff, head_idx_in;
   logic [CW-1:0] total_ff, total_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [IW-1:0] init_ff, init_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] step_ff, step_in;
   logic          chain_ok_ff, chain_ok_in;
   logic [IW-1:0] chain_idx_ff, chain_idx_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IW-1:0]       rsp_index_ff, rsp_index_in;
   logic                rsp_present_ff, rsp_present_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [LW-1:0] ram_wdata;
   logic [LW-1:0] ram_rdata;
   logic          rd_ok;
   logic [IW-1:0] rd_idx;

   logic [IW+IDX_W-1:0] bidx_ext;
   logic [IW-1:0]       bidx;
   logic                bidx_oor;
   logic [IDX_W+IW-1:0] rsp_index_ext;
   logic [CNT_W+CW-1:0] total_ext;
   logic [CW-1:0]       total_inc;
   logic [CW-1:0]       total_dec;

   fbfla_ram #(
      .WIDTH (LW),
      .DEPTH (NUM_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rd_ok  = ram_rdata[IW];
   assign rd_idx = ram_rdata[IW-1:0];

   assign bidx_ext = {{IW{1'b0}}, req_block_index};
   assign bidx     = bidx_ext[IW-1:0];
   assign bidx_oor = {{(32-IDX_W){1'b0}}, req_block_index} >= 32'(NUM_BLOCKS);

   // saturating counter updates
   assign total_inc = (total_ff != CW'(NUM_BLOCKS)) ? total_ff + CW'(1) : total_ff;
   assign total_dec = (total_ff != '0) ? total_ff - CW'(1) : total_ff;

   always_comb begin
      state_in       = state_ff;
      after_in       = after_ff;
      head_ok_in     = head_ok_ff;
      head_idx_in    = head_idx_ff;
      total_in       = total_ff;
      addr_in        = addr_ff;
      init_in        = init_ff;
      n_in           = n_ff;
      cnt_in         = cnt_ff;
      step_in        = step_ff;
      chain_ok_in    = chain_ok_ff;
      chain_idx_in   = chain_idx_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_present_in = rsp_present_ff;
      ram_we         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = '0;

      unique case (state_ff)
         ST_INIT: begin
            // entry i links to i-1, entry 0 is null
            ram_we    = 1'b1;
            ram_waddr = init_ff;
            ram_wdata = {init_ff != '0, init_ff - IW'(1)};
            if (init_ff == IW'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               init_in = init_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               cnt_in = req_block_count;
               unique case (req_code_type'(req_type))
                  REQ_ALLOC_ONE: begin
                     if (!head_ok_ff) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_status_in  = STATUS_CAP;
                        rsp_index_in   = '0;
                        rsp_present_in = 1'b0;
                     end else begin
                        addr_in  = head_idx_ff;
                        after_in = ST_ALLOC;
                        state_in = ST_READ;
                     end
                  end
                  REQ_ALLOC_LIST: begin
                     if (req_block_count == '0) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_status_in  = STATUS_OK;
                        rsp_index_in   = '0;
                        rsp_present_in = 1'b0;
                     end else if (!head_ok_ff) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_status_in  = STATUS_CAP;
                        rsp_index_in   = '0;
                        rsp_present_in = 1'b0;
                     end else begin
                        // head counts as the first block seen
                        addr_in  = head_idx_ff;
                        n_in     = CNT_W'(1);
                        after_in = ST_WALK;
                        state_in = ST_READ;
                     end
                  end
                  REQ_FREE_ONE, REQ_FREE_LIST: begin
                     if (!req_block_present) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_status_in  = STATUS_OK;
                        rsp_index_in   = '0;
                        rsp_present_in = 1'b0;
                     end else if (bidx_oor) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_status_in  = STATUS_RANGE;
                        rsp_index_in   = '0;
                        rsp_present_in = 1'b0;
                     end else if (req_code_type'(req_type) == REQ_FREE_ONE) begin
                        ram_we         = 1'b1;
                        ram_waddr      = bidx;
                        ram_wdata      = {head_ok_ff, head_idx_ff};
                        head_ok_in     = 1'b1;
                        head_idx_in    = bidx;
                        total_in       = total_inc;
                        rsp_strobe_in  = 1'b1;
                        rsp_status_in  = STATUS_OK;
                        rsp_index_in   = '0;
                        rsp_present_in = 1'b0;
                     end else begin
                        addr_in  = bidx;
                        step_in  = '0;
                        after_in = ST_FREE;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = after_ff;
         end
         ST_ALLOC: begin
            head_ok_in     = rd_ok;
            head_idx_in    = rd_idx;
            total_in       = total_dec;
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = STATUS_OK;
            rsp_index_in   = addr_ff;
            rsp_present_in = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_WALK: begin
            // count reachable blocks before touching the list
            if (n_ff == cnt_ff) begin
               n_in         = '0;
               chain_ok_in  = 1'b0;
               chain_idx_in = '0;
               addr_in      = head_idx_ff;
               after_in     = ST_CHAIN;
               state_in     = ST_READ;
            end else if (!rd_ok) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STATUS_CAP;
               rsp_index_in   = '0;
               rsp_present_in = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               n_in     = n_ff + CNT_W'(1);
               addr_in  = rd_idx;
               state_in = ST_READ;
            end
         end
         ST_CHAIN: begin
            // pop the head and link it to the previously popped block
            ram_we       = 1'b1;
            ram_waddr    = addr_ff;
            ram_wdata    = {chain_ok_ff, chain_idx_ff};
            head_ok_in   = rd_ok;
            head_idx_in  = rd_idx;
            chain_ok_in  = 1'b1;
            chain_idx_in = addr_ff;
            total_in     = total_dec;
            n_in         = n_ff + CNT_W'(1);
            if ((n_ff + CNT_W'(1) == cnt_ff) || !rd_ok) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_index_in   = addr_ff;
               rsp_present_in = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               addr_in  = rd_idx;
               state_in = ST_READ;
            end
         end
         ST_FREE: begin
            // push the current block, follow its old link
            ram_we      = 1'b1;
            ram_waddr   = addr_ff;
            ram_wdata   = {head_ok_ff, head_idx_ff};
            head_ok_in  = 1'b1;
            head_idx_in = addr_ff;
            total_in    = total_inc;
            step_in     = step_ff + CW'(1);
            if (!rd_ok || (step_ff == CW'(NUM_BLOCKS - 1))) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_index_in   = '0;
               rsp_present_in = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               addr_in  = rd_idx;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         after_ff      <= ST_IDLE;
         head_ok_ff    <= 1'b1;
         head_idx_ff   <= IW'(NUM_BLOCKS - 1);
         total_ff      <= CW'(NUM_BLOCKS);
         init_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         after_ff      <= after_in;
         head_ok_ff    <= head_ok_in;
         head_idx_ff   <= head_idx_in;
         total_ff      <= total_in;
         init_ff       <= init_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      n_ff           <= n_in;
      cnt_ff         <= cnt_in;
      step_ff        <= step_in;
      chain_ok_ff    <= chain_ok_in;
      chain_idx_ff   <= chain_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_present_ff <= rsp_present_in;
   end

   assign rsp_index_ext = {{IDX_W{1'b0}}, rsp_index_ff};
   assign total_ext     = {{CNT_W{1'b0}}, total_ff};

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_index   = rsp_index_ext[IDX_W-1:0];
   assign rsp_result_present = rsp_present_ff;
   // the count register holds the post-transaction value while the strobe is up
   assign rsp_free_blocks    = total_ext[CNT_W-1:0];

endmodule

FILE: hw/rtl/fbfla_ram.sv
module fbfla_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_fixed_block_free_list_allocator_core.sv
`timescale 1ns / 1ps
module tb_fixed_block_free_list_allocator_core;
   import fbfla_pkg::*;

   localparam int NBLK = NUM_BLOCKS_DEFAULT;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic                present;
      logic [CNT_W-1:0]    free_blocks;
   } pool_reply_type;

   typedef struct {
      req_code_type     kind;
      logic [IDX_W-1:0] index;
      logic             present;
      logic [CNT_W-1:0] count;
      bit               known;
      pool_reply_type   reply;
   } pool_req_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [IDX_W-1:0]    req_block_index;
   logic                req_block_present;
   logic [CNT_W-1:0]    req_block_count;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_result_index;
   logic                rsp_result_present;
   logic [CNT_W-1:0]    rsp_free_blocks;

   fixed_block_free_list_allocator_core #(
      .NUM_BLOCKS(NBLK)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_block_index    (req_block_index),
      .req_block_present  (req_block_present),
      .req_block_count    (req_block_count),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_result_index   (rsp_result_index),
      .rsp_result_present (rsp_result_present),
      .rsp_free_blocks    (rsp_free_blocks)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #400_000_000;
      $display("simulation failed");
      $finish;
   end

   // shadow copy of the pool
   bit  head_ok;
   int  head_at;
   bit  link_ok [NBLK];
   int  link_to [NBLK];
   int  free_cnt;

   pool_reply_type pending_replies [$];
   pool_req_type   plan [$];
   pool_req_type   drive_req;
   int             held_singles [$];
   int             held_chains [$];
   int             mismatch_count = 0;
   int             burst_left = 0;

   function automatic void reset_pool_model();
      for (int i = 0; i < NBLK; i++) begin
         link_ok[i] = (i != 0);
         link_to[i] = (i != 0) ? i - 1 : 0;
      end
      head_ok  = 1'b1;
      head_at  = NBLK - 1;
      free_cnt = NBLK;
   endfunction

   // stray link indexes read as null
   function automatic void read_next(input int i, output bit ok, output int to);
      ok = 1'b0;
      to = 0;
      if (i < NBLK && link_to[i] < NBLK) begin
         ok = link_ok[i];
         to = link_to[i];
      end
   endfunction

   function automatic void push_free(input int b);
      if (b >= NBLK) return;
      link_ok[b] = head_ok;
      link_to[b] = head_at;
      head_ok = 1'b1;
      head_at = b;
      if (free_cnt < NBLK) free_cnt++;
   endfunction

   function automatic int pop_free();
      int b;
      b = head_at;
      read_next(b, head_ok, head_at);
      if (free_cnt > 0) free_cnt--;
      return b;
   endfunction

   function automatic pool_reply_type predict_pool_reply(input pool_req_type r);
      pool_reply_type y;
      int n, b, cur, nx_to, p_at, chain_at;
      bit p_ok, nx_ok, chain_ok;
      y = '{STATUS_OK, '0, 1'b0, '0};
      case (r.kind)
         REQ_ALLOC_ONE: begin
            if (!head_ok || head_at >= NBLK) begin
               y.status = STATUS_CAP;
            end else begin
               y.index   = IDX_W'(pop_free());
               y.present = 1'b1;
            end
         end
         REQ_ALLOC_LIST: begin
            if (r.count != 0) begin
               // dry walk first so a short list leaves everything untouched
               n = 0;
               p_ok = head_ok && head_at < NBLK;
               p_at = head_at;
               while (n < r.count && p_ok) begin
                  n++;
                  read_next(p_at, p_ok, p_at);
               end
               if (n < r.count) begin
                  y.status = STATUS_CAP;
               end else begin
                  chain_ok = 1'b0;
                  chain_at = 0;
                  for (n = 0; n < r.count; n++) begin
                     if (!head_ok) break;
                     b = pop_free();
                     link_ok[b] = chain_ok;
                     link_to[b] = chain_at;
                     chain_ok = 1'b1;
                     chain_at = b;
                  end
                  y.present = chain_ok;
                  y.index   = chain_ok ? IDX_W'(chain_at) : '0;
               end
            end
         end
         default: begin
            if (r.present) begin
               if (r.index >= NBLK) begin
                  y.status = STATUS_RANGE;
               end else if (r.kind == REQ_FREE_ONE) begin
                  push_free(int'(r.index));
               end else begin
                  // long or looping chains are cut after one pool's worth
                  cur = int'(r.index);
                  for (n = 0; n < NBLK; n++) begin
                     read_next(cur, nx_ok, nx_to);
                     push_free(cur);
                     if (!nx_ok) break;
                     cur = nx_to;
                  end
               end
            end
         end
      endcase
      y.free_blocks = CNT_W'(free_cnt);
      return y;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      pool_reply_type got, want, guess;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_status, rsp_result_index, rsp_result_present, rsp_free_blocks};
            if (pending_replies.size() == 0) begin
               $display("%0t: response with none outstanding, expected none, actual %0d %0d %0d %0d",
                        $time, got.status, got.index, got.present, got.free_blocks);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               check_field("status", int'(want.status), int'(got.status));
               check_field("result_index", int'(want.index), int'(got.index));
               check_field("result_present", int'(want.present), int'(got.present));
               check_field("free_blocks", int'(want.free_blocks), int'(got.free_blocks));
            end
         end
         if (start && !busy) begin
            guess = predict_pool_reply(drive_req);
            if (guess.present && drive_req.kind == REQ_ALLOC_ONE)
               held_singles.push_back(int'(guess.index));
            if (guess.present && drive_req.kind == REQ_ALLOC_LIST)
               held_chains.push_back(int'(guess.index));
            pending_replies.push_back(drive_req.known ? drive_req.reply : guess);
         end
      end
   end

   task automatic add_row(input req_code_type kind, input int index, input bit present,
                          input int count, input bit known = 1'b0,
                          input logic [STATUS_W-1:0] status = STATUS_OK, input int rindex = 0,
                          input bit rpresent = 1'b0, input int rfree = 0);
      pool_req_type r;
      r.kind    = kind;
      r.index   = IDX_W'(index);
      r.present = present;
      r.count   = CNT_W'(count);
      r.known   = known;
      r.reply   = '{status, IDX_W'(rindex), rpresent, CNT_W'(rfree)};
      plan.push_back(r);
   endtask

   function automatic int take_held(inout int held [$]);
      int k, v;
      if (held.size() == 0) return $urandom_range(0, NBLK - 1);
      k = $urandom_range(0, held.size() - 1);
      v = held[k];
      held.delete(k);
      return v;
   endfunction

   function automatic pool_req_type make_random_req(input bit draining);
      pool_req_type r;
      int roll, share;
      r.kind    = req_code_type'($urandom_range(0, 3));
      r.index   = IDX_W'($urandom_range(0, NBLK - 1));
      r.present = 1'($urandom_range(0, 1));
      r.count   = ($urandom_range(0, 49) == 0) ? CNT_W'($urandom_range(0, 2047))
                                                : CNT_W'($urandom_range(0, 20));
      r.known   = 1'b0;
      r.reply   = '{STATUS_OK, '0, 1'b0, '0};
      if ($urandom_range(0, 99) >= 12) begin
         // well-formed transaction on blocks this side actually holds
         share = draining ? 70 : 30;
         roll  = $urandom_range(0, 99);
         r.present = 1'b1;
         if (roll < share / 2) begin
            r.kind = REQ_ALLOC_ONE;
         end else if (roll < share) begin
            r.kind  = REQ_ALLOC_LIST;
            r.count = ($urandom_range(0, 39) == 0) ? CNT_W'($urandom_range(64, 1024))
                                                    : CNT_W'($urandom_range(1, 16));
         end else if (roll < share + (100 - share) / 2) begin
            r.kind  = REQ_FREE_ONE;
            r.index = IDX_W'(take_held(held_singles));
         end else begin
            r.kind  = REQ_FREE_LIST;
            r.index = IDX_W'(take_held(held_chains));
         end
      end
      return r;
   endfunction

   task automatic issue(input pool_req_type r);
      @(negedge clock);
      drive_req = r;
      start             <= 1'b1;
      req_type          <= r.kind;
      req_block_index   <= r.index;
      req_block_present <= r.present;
      req_block_count   <= r.count;
      do @(posedge clock); while (busy);
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   initial begin
      int  phase_left;
      bit  draining;
      reset_pool_model();
      reset             <= 1'b1;
      start             <= 1'b0;
      req_type          <= REQ_ALLOC_ONE;
      req_block_index   <= '0;
      req_block_present <= 1'b0;
      req_block_count   <= '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(REQ_ALLOC_ONE, 0, 0, 0, 1, STATUS_OK, 1023, 1, 1023);
      add_row(REQ_ALLOC_ONE, 1023, 1, 2047, 1, STATUS_OK, 1022, 1, 1022);
      add_row(REQ_FREE_ONE, 1023, 1, 0, 1, STATUS_OK, 0, 0, 1023);
      add_row(REQ_FREE_ONE, 5, 0, 0, 1, STATUS_OK, 0, 0, 1023);
      add_row(REQ_FREE_LIST, 1023, 0, 0, 1, STATUS_OK, 0, 0, 1023);
      add_row(REQ_ALLOC_LIST, 0, 0, 0, 1, STATUS_OK, 0, 0, 1023);
      add_row(REQ_ALLOC_LIST, 0, 1, 3);
      add_row(REQ_FREE_LIST, 1020, 1, 0);
      add_row(REQ_ALLOC_LIST, 0, 0, 1023);
      // pool drained
      add_row(REQ_ALLOC_ONE, 0, 0, 0, 1, STATUS_CAP, 0, 0, 0);
      add_row(REQ_ALLOC_LIST, 0, 0, 1, 1, STATUS_CAP, 0, 0, 0);
      add_row(REQ_ALLOC_LIST, 0, 0, 2047, 1, STATUS_CAP, 0, 0, 0);
      add_row(REQ_FREE_ONE, 1022, 1, 0, 1, STATUS_OK, 0, 0, 1);
      add_row(REQ_FREE_LIST, 0, 1, 0, 1, STATUS_OK, 0, 0, 1024);
      add_row(REQ_ALLOC_LIST, 0, 0, 1024);
      add_row(REQ_ALLOC_LIST, 0, 0, 1025, 1, STATUS_CAP, 0, 0, 0);
      add_row(REQ_FREE_LIST, 1022, 1, 0);
      // double free saturates the counter and leaves a loop in the list
      add_row(REQ_FREE_ONE, 5, 1, 0, 1, STATUS_OK, 0, 0, 1024);
      add_row(REQ_FREE_LIST, 512, 1, 0);
      add_row(REQ_ALLOC_LIST, 0, 0, 2047);
      add_row(REQ_ALLOC_ONE, 0, 0, 0);
      add_row(REQ_FREE_ONE, 0, 1, 1024);
      add_row(REQ_FREE_ONE, 1023, 1, 0);
      add_row(REQ_FREE_LIST, 341, 1, 682);
      add_row(REQ_ALLOC_LIST, 682, 1, 8);
      foreach (plan[i]) begin
         issue(plan[i]);
         pace();
      end

      phase_left = 0;
      draining   = 1'b1;
      repeat (1100) begin
         if (phase_left == 0) begin
            draining   = !draining;
            phase_left = $urandom_range(50, 150);
         end
         phase_left--;
         issue(make_random_req(draining));
         pace();
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
